FILE: rtl/rls_pkg.sv
// Package: shared types, constants and saturating arithmetic helpers.
`timescale 1ns / 1ps
package rls_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  typedef logic signed [DW-1:0] q_t;

  localparam q_t QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(DW-1){1'b0}}};
  localparam q_t ONE_Q = q_t'(1) <<< FB;

  localparam logic [16:0] LAMBDA_RST = 17'd62259;
  localparam logic [16:0] PERIOD_RST = 17'd1638;
  localparam q_t PROP_RST = 32'sd33292;
  localparam q_t INTEG_RST = 32'sd79299;

  localparam logic [1:0] REG_LAMBDA = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_PROP = 2'd2;
  localparam logic [1:0] REG_INTEG = 2'd3;

  // ALU operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Register file slots
  localparam int NREG = 32;
  localparam int RW = 5;
  localparam logic [RW-1:0] R_ZERO = 5'd0;
  localparam logic [RW-1:0] R_LAM = 5'd1;
  localparam logic [RW-1:0] R_HT = 5'd2;
  localparam logic [RW-1:0] R_PROP = 5'd3;
  localparam logic [RW-1:0] R_INTEG = 5'd4;
  localparam logic [RW-1:0] R_MEAS = 5'd5;
  localparam logic [RW-1:0] R_TGT = 5'd6;
  localparam logic [RW-1:0] R_YP = 5'd7;
  localparam logic [RW-1:0] R_UP = 5'd8;
  localparam logic [RW-1:0] R_E = 5'd9;
  localparam logic [RW-1:0] R_EP = 5'd10;
  localparam logic [RW-1:0] R_GA = 5'd11;
  localparam logic [RW-1:0] R_GB = 5'd12;
  localparam logic [RW-1:0] R_C00 = 5'd13;
  localparam logic [RW-1:0] R_C01 = 5'd14;
  localparam logic [RW-1:0] R_C10 = 5'd15;
  localparam logic [RW-1:0] R_C11 = 5'd16;
  localparam logic [RW-1:0] R_R0 = 5'd17;
  localparam logic [RW-1:0] R_T1 = 5'd18;
  localparam logic [RW-1:0] R_T2 = 5'd19;
  localparam logic [RW-1:0] R_RES = 5'd20;
  localparam logic [RW-1:0] R_V0 = 5'd21;
  localparam logic [RW-1:0] R_V1 = 5'd22;
  localparam logic [RW-1:0] R_W0 = 5'd23;
  localparam logic [RW-1:0] R_W1 = 5'd24;
  localparam logic [RW-1:0] R_DEN = 5'd25;
  localparam logic [RW-1:0] R_K0 = 5'd26;
  localparam logic [RW-1:0] R_K1 = 5'd27;
  localparam logic [RW-1:0] R_KP = 5'd28;
  localparam logic [RW-1:0] R_KI = 5'd29;
  localparam logic [RW-1:0] R_DRV = 5'd30;
  localparam logic [RW-1:0] R_T3 = 5'd31;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
    logic [RW-1:0] ra;
    logic [RW-1:0] rb;
    logic [RW-1:0] rd;
    logic       neg_b;
    logic       load_in;
    logic       clr_div;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic div_zero;
    logic den_zero;
    logic lam_zero;
    logic gb_zero;
  } sts_t;

  function automatic q_t sat_add(input q_t a, input q_t b, output logic ov);
    logic signed [DW:0] s;
    begin
      s = {a[DW-1], a} + {b[DW-1], b};
      ov = (s[DW] != s[DW-1]);
      if (ov) begin
        sat_add = s[DW] ? QMIN : QMAX;
      end else begin
        sat_add = s[DW-1:0];
      end
    end
  endfunction

  function automatic q_t sat_neg(input q_t a, output logic ov);
    begin
      ov = (a == QMIN);
      sat_neg = ov ? QMAX : -a;
    end
  endfunction

  function automatic q_t from_mag(input logic neg, input logic [DW:0] m, output logic ov);
    begin
      ov = 1'b0;
      if (!neg && m > {1'b0, QMAX}) begin
        ov = 1'b1;
        from_mag = QMAX;
      end else if (neg && m > {2'b01, {(DW-1){1'b0}}}) begin
        ov = 1'b1;
        from_mag = QMIN;
      end else begin
        from_mag = neg ? q_t'(-m[DW-1:0]) : q_t'(m[DW-1:0]);
      end
    end
  endfunction

endpackage

FILE: rtl/rls_dp.sv
// Datapath: register file, saturating adder, multiplier and serial divider.
`timescale 1ns / 1ps
module rls_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rls_pkg::cmd_t   cmd_i,
  output rls_pkg::sts_t   sts_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic [31:0]     meas_i,
  input  logic [31:0]     tgt_i,
  input  logic            commit_i,
  input  logic            hold_drive_i,
  output logic [31:0]     drive_o,
  output logic [31:0]     pole_o,
  output logic [31:0]     gain_o,
  output logic            sat_o
);
  import rls_pkg::*;

  localparam int CW = $clog2(DW + FB + 1);

  q_t rf_q [NREG];
  logic [16:0] lam_q, per_q;
  q_t prop_q, integ_q;

  q_t a_v, b_v, b_in, add_r, neg_r;
  logic add_ov, neg_ov;

  // multiply pipeline
  logic mul_busy_q;
  logic [2*DW-1:0] prod_q;
  logic mneg_q;
  logic [RW-1:0] rd_q;

  // divider
  logic div_busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW+FB-1:0] num_q;
  logic [DW:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW+FB-1:0] quo_q;
  logic dneg_q;
  logic [DW:0] rsh;
  logic [DW:0] rsub;

  logic sat_q, done_q, divz_q;
  q_t wr_val;
  logic wr_en, wr_ov;
  logic [RW-1:0] wr_addr;
  logic mov;
  q_t mres;
  logic [2*DW-FB-1:0] mshift;
  logic mbig;
  q_t dres;
  logic dov;
  logic [DW:0] mag_a, mag_b;

  assign a_v = rf_q[cmd_i.ra];
  assign b_v = rf_q[cmd_i.rb];
  assign mag_a = a_v[DW-1] ? -{a_v[DW-1], a_v} : {1'b0, a_v};
  assign mag_b = b_v[DW-1] ? -{b_v[DW-1], b_v} : {1'b0, b_v};

  always_comb begin
    neg_r = sat_neg(b_v, neg_ov);
    b_in = cmd_i.neg_b ? neg_r : b_v;
    add_r = sat_add(a_v, b_in, add_ov);
  end

  assign mshift = prod_q[2*DW-1:FB];
  assign mbig = |mshift[2*DW-FB-1:DW+1];
  always_comb begin
    mres = from_mag(mneg_q, mshift[DW:0], mov);
    if (mbig) begin
      mov = 1'b1;
      mres = mneg_q ? QMIN : QMAX;
    end
  end

  assign rsh = {rem_q[DW-1:0], num_q[DW+FB-1]};
  assign rsub = rsh - {1'b0, dvs_q};
  always_comb begin
    dres = from_mag(dneg_q, {1'b0, quo_q[DW-1:0]}, dov);
    if (|quo_q[DW+FB-1:DW]) begin
      dov = 1'b1;
      dres = dneg_q ? QMIN : QMAX;
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_val = add_r;
    wr_addr = cmd_i.rd;
    wr_ov = 1'b0;
    if (cmd_i.go && (cmd_i.op == OP_ADD || cmd_i.op == OP_SUB)) begin
      wr_en = 1'b1;
      wr_ov = add_ov | (cmd_i.neg_b & neg_ov);
    end else if (mul_busy_q) begin
      wr_en = 1'b1;
      wr_val = mres;
      wr_addr = rd_q;
      wr_ov = mov;
    end else if (div_busy_q && cnt_q == '0) begin
      wr_en = 1'b1;
      wr_val = dres;
      wr_addr = rd_q;
      wr_ov = dov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q <= LAMBDA_RST;
      per_q <= PERIOD_RST;
      prop_q <= PROP_RST;
      integ_q <= INTEG_RST;
      for (int i = 0; i < NREG; i++) rf_q[i] <= '0;
      rf_q[R_GA] <= ONE_Q;
      rf_q[R_GB] <= ONE_Q;
      rf_q[R_C00] <= ONE_Q;
      rf_q[R_C11] <= ONE_Q;
      mul_busy_q <= 1'b0;
      div_busy_q <= 1'b0;
      sat_q <= 1'b0;
      done_q <= 1'b0;
      divz_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LAMBDA: lam_q <= cfg_data_i[16:0];
          REG_PERIOD: per_q <= cfg_data_i[16:0];
          REG_PROP: prop_q <= cfg_data_i;
          REG_INTEG: integ_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_in) begin
        rf_q[R_MEAS] <= meas_i;
        rf_q[R_TGT] <= tgt_i;
        rf_q[R_LAM] <= q_t'({15'd0, lam_q});
        rf_q[R_HT] <= q_t'({16'd0, per_q[16:1]});
        rf_q[R_PROP] <= prop_q;
        rf_q[R_INTEG] <= integ_q;
        sat_q <= 1'b0;
        divz_q <= 1'b0;
      end
      if (cmd_i.clr_div) divz_q <= 1'b0;
      if (wr_en) begin
        if (wr_addr != R_ZERO) rf_q[wr_addr] <= wr_val;
        if (wr_ov) sat_q <= 1'b1;
        done_q <= 1'b1;
      end
      if (mul_busy_q) mul_busy_q <= 1'b0;
      if (cmd_i.go && cmd_i.op == OP_MUL) begin
        prod_q <= mag_a[DW-1:0] * mag_b[DW-1:0];
        mneg_q <= a_v[DW-1] ^ b_v[DW-1];
        rd_q <= cmd_i.rd;
        mul_busy_q <= 1'b1;
      end
      if (cmd_i.go && cmd_i.op == OP_DIV) begin
        rd_q <= cmd_i.rd;
        if (b_v == '0) begin
          rf_q[cmd_i.rd] <= '0;
          divz_q <= 1'b1;
          done_q <= 1'b1;
        end else begin
          num_q <= {mag_a[DW-1:0], {FB{1'b0}}};
          dvs_q <= mag_b[DW-1:0];
          rem_q <= '0;
          quo_q <= '0;
          dneg_q <= a_v[DW-1] ^ b_v[DW-1];
          cnt_q <= CW'(DW + FB);
          div_busy_q <= 1'b1;
        end
      end else if (div_busy_q) begin
        if (cnt_q == '0) begin
          div_busy_q <= 1'b0;
        end else begin
          num_q <= num_q << 1;
          if (!rsub[DW]) begin
            rem_q <= rsub;
            quo_q <= {quo_q[DW+FB-2:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[DW+FB-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (commit_i) begin
        rf_q[R_YP] <= rf_q[R_MEAS];
        rf_q[R_UP] <= hold_drive_i ? rf_q[R_UP] : rf_q[R_DRV];
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.div_zero = divz_q;
  assign sts_o.den_zero = (rf_q[R_DEN] == '0);
  assign sts_o.lam_zero = (rf_q[R_LAM] == '0);
  assign sts_o.gb_zero = (rf_q[R_GB] == '0);
  assign drive_o = hold_drive_i ? rf_q[R_UP] : rf_q[R_DRV];
  assign pole_o = rf_q[R_GA];
  assign gain_o = rf_q[R_GB];
  assign sat_o = sat_q;
endmodule

FILE: rtl/rls_ctrl.sv
// Controller: microprogram sequencer issuing datapath operations per sample.
`timescale 1ns / 1ps
module rls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rls_pkg::sts_t sts_i,
  output rls_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          finish_o,
  output logic          commit_o,
  output logic          hold_drive_o,
  output logic          div_flag_o
);
  import rls_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int PW = 6;
  localparam logic [PW-1:0] P_CHECK_DEN = 6'd21;
  localparam logic [PW-1:0] P_CHECK_GB = 6'd41;

  typedef struct packed {
    logic [1:0] op;
    logic [RW-1:0] ra;
    logic [RW-1:0] rb;
    logic [RW-1:0] rd;
    logic neg_b;
  } uop_t;

  function automatic uop_t prog(input logic [PW-1:0] pc);
    case (pc)
      6'd0:  prog = '{OP_SUB, R_ZERO, R_YP, R_R0, 1'b1};
      6'd1:  prog = '{OP_MUL, R_R0, R_GA, R_T1, 1'b0};
      6'd2:  prog = '{OP_MUL, R_UP, R_GB, R_T2, 1'b0};
      6'd3:  prog = '{OP_ADD, R_T1, R_T2, R_T1, 1'b0};
      6'd4:  prog = '{OP_SUB, R_MEAS, R_T1, R_RES, 1'b1};
      6'd5:  prog = '{OP_MUL, R_C00, R_R0, R_T1, 1'b0};
      6'd6:  prog = '{OP_MUL, R_C01, R_UP, R_T2, 1'b0};
      6'd7:  prog = '{OP_ADD, R_T1, R_T2, R_V0, 1'b0};
      6'd8:  prog = '{OP_MUL, R_C10, R_R0, R_T1, 1'b0};
      6'd9:  prog = '{OP_MUL, R_C11, R_UP, R_T2, 1'b0};
      6'd10: prog = '{OP_ADD, R_T1, R_T2, R_V1, 1'b0};
      6'd11: prog = '{OP_MUL, R_R0, R_C00, R_T1, 1'b0};
      6'd12: prog = '{OP_MUL, R_UP, R_C10, R_T2, 1'b0};
      6'd13: prog = '{OP_ADD, R_T1, R_T2, R_W0, 1'b0};
      6'd14: prog = '{OP_MUL, R_R0, R_C01, R_T1, 1'b0};
      6'd15: prog = '{OP_MUL, R_UP, R_C11, R_T2, 1'b0};
      6'd16: prog = '{OP_ADD, R_T1, R_T2, R_W1, 1'b0};
      6'd17: prog = '{OP_MUL, R_W0, R_R0, R_T1, 1'b0};
      6'd18: prog = '{OP_MUL, R_W1, R_UP, R_T2, 1'b0};
      6'd19: prog = '{OP_ADD, R_T1, R_T2, R_T1, 1'b0};
      6'd20: prog = '{OP_ADD, R_LAM, R_T1, R_DEN, 1'b0};
      6'd21: prog = '{OP_DIV, R_V0, R_DEN, R_K0, 1'b0};
      6'd22: prog = '{OP_DIV, R_V1, R_DEN, R_K1, 1'b0};
      6'd23: prog = '{OP_MUL, R_K0, R_W0, R_T1, 1'b0};
      6'd24: prog = '{OP_SUB, R_C00, R_T1, R_T1, 1'b1};
      6'd25: prog = '{OP_MUL, R_K0, R_W1, R_T2, 1'b0};
      6'd26: prog = '{OP_SUB, R_C01, R_T2, R_T2, 1'b1};
      6'd27: prog = '{OP_MUL, R_K1, R_W0, R_T3, 1'b0};
      6'd28: prog = '{OP_SUB, R_C10, R_T3, R_T3, 1'b1};
      6'd29: prog = '{OP_MUL, R_K1, R_W1, R_V0, 1'b0};
      6'd30: prog = '{OP_SUB, R_C11, R_V0, R_V0, 1'b1};
      6'd31: prog = '{OP_DIV, R_T1, R_LAM, R_C00, 1'b0};
      6'd32: prog = '{OP_DIV, R_T2, R_LAM, R_C01, 1'b0};
      6'd33: prog = '{OP_DIV, R_T3, R_LAM, R_C10, 1'b0};
      6'd34: prog = '{OP_DIV, R_V0, R_LAM, R_C11, 1'b0};
      6'd35: prog = '{OP_MUL, R_K0, R_RES, R_T1, 1'b0};
      6'd36: prog = '{OP_ADD, R_GA, R_T1, R_GA, 1'b0};
      6'd37: prog = '{OP_MUL, R_K1, R_RES, R_T1, 1'b0};
      6'd38: prog = '{OP_ADD, R_GB, R_T1, R_GB, 1'b0};
      6'd39: prog = '{OP_ADD, R_E, R_ZERO, R_EP, 1'b0};
      6'd40: prog = '{OP_SUB, R_TGT, R_MEAS, R_E, 1'b1};
      6'd41: prog = '{OP_SUB, R_PROP, R_GA, R_T1, 1'b1};
      6'd42: prog = '{OP_DIV, R_T1, R_GB, R_KP, 1'b0};
      6'd43: prog = '{OP_DIV, R_INTEG, R_GB, R_KI, 1'b0};
      6'd44: prog = '{OP_SUB, R_E, R_EP, R_T1, 1'b1};
      6'd45: prog = '{OP_MUL, R_KP, R_T1, R_T1, 1'b0};
      6'd46: prog = '{OP_MUL, R_KI, R_HT, R_T2, 1'b0};
      6'd47: prog = '{OP_ADD, R_E, R_EP, R_T3, 1'b0};
      6'd48: prog = '{OP_MUL, R_T2, R_T3, R_T2, 1'b0};
      6'd49: prog = '{OP_ADD, R_T1, R_T2, R_T1, 1'b0};
      6'd50: prog = '{OP_ADD, R_UP, R_T1, R_DRV, 1'b0};
      default: prog = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO, 1'b0};
    endcase
  endfunction

  localparam logic [PW-1:0] P_ERR = 6'd39;
  localparam logic [PW-1:0] P_LAST = 6'd50;

  logic [1:0] st_q, st_d;
  logic [PW-1:0] pc_q, pc_d;
  logic hold_q, hold_d, divf_q, divf_d;
  uop_t u;
  logic fin;

  assign u = prog(pc_q);

  always_comb begin
    st_d = st_q;
    pc_d = pc_q;
    hold_d = hold_q;
    divf_d = divf_q;
    fin = 1'b0;
    cmd_o = '0;
    cmd_o.op = u.op;
    cmd_o.ra = u.ra;
    cmd_o.rb = u.rb;
    cmd_o.rd = u.rd;
    cmd_o.neg_b = u.neg_b;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          pc_d = '0;
          hold_d = 1'b0;
          divf_d = 1'b0;
          st_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (pc_q == P_CHECK_DEN && (sts_i.den_zero || sts_i.lam_zero)) begin
          divf_d = 1'b1;
          pc_d = P_ERR;
        end else if (pc_q == P_CHECK_GB && sts_i.gb_zero) begin
          divf_d = 1'b1;
          hold_d = 1'b1;
          st_d = S_DONE;
        end else begin
          cmd_o.go = 1'b1;
          st_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.done) begin
          if (sts_i.div_zero) divf_d = 1'b1;
          cmd_o.clr_div = 1'b1;
          if (pc_q == P_LAST) begin
            st_d = S_DONE;
          end else begin
            pc_d = pc_q + 1'b1;
            st_d = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        fin = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      pc_q <= '0;
      hold_q <= 1'b0;
      divf_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
      hold_q <= hold_d;
      divf_q <= divf_d;
    end
  end

  assign busy_o = (st_q != S_IDLE);
  assign finish_o = fin;
  assign commit_o = fin;
  assign hold_drive_o = hold_q;
  assign div_flag_o = divf_q;
endmodule

FILE: rtl/rls_self_tuning_pi_regulator_top.sv
// Top level: self-tuning PI regulator with RLS plant identification.
// Each input transaction runs the 51-step microprogram, steps issued one at a
// time, before out_valid_o; quotients (8 of them) come from a bit-serial divider.
// A zero gain denominator skips the estimate update; a zero gain estimate ends early.
// Samples are processed one at a time; in_ready_o rises the cycle after the result
// transaction.
// Reset: asynchronous active low; estimates 1.0, covariance identity, history 0.
`timescale 1ns / 1ps
module rls_self_tuning_pi_regulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] measured_speed_i,
  input  logic [31:0] target_speed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] drive_out_o,
  output logic [31:0] est_pole_o,
  output logic [31:0] est_gain_o,
  output logic [1:0]  fault_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import rls_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy, fin, commit, hold, divf, sat, start;
  logic [31:0] drv, pole, gain;
  logic ov_q;

  assign in_ready_o = !busy && !ov_q;
  assign start = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  rls_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .finish_o(fin), .commit_o(commit),
    .hold_drive_o(hold), .div_flag_o(divf)
  );

  rls_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .meas_i(measured_speed_i), .tgt_i(target_speed_i),
    .commit_i(commit), .hold_drive_i(hold),
    .drive_o(drv), .pole_o(pole), .gain_o(gain), .sat_o(sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (fin) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      drive_out_o <= drv;
      est_pole_o <= pole;
      est_gain_o <= gain;
      fault_flag_o <= {sat, divf};
    end
  end

  assign out_valid_o = ov_q;
endmodule
